// ===== hdl/erx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_pkg
// Types and constants shared by the escaped ymodem frame receiver.
// ----------------------------------------------------------------------------
package erx_pkg;

  localparam logic [7:0] ESC_MARK     = 8'h7d;
  localparam logic [7:0] ESC_XOR      = 8'h20;
  localparam logic [7:0] CH_SOH       = 8'h01;
  localparam logic [7:0] CH_STX       = 8'h02;
  localparam logic [7:0] CH_EOT       = 8'h04;
  localparam logic [7:0] CH_ABORT_LOW = 8'h61;

  localparam int unsigned FRAME_OVERHEAD = 5;
  localparam int unsigned IDX_W          = 11;

  localparam logic [1:0] STATUS_IGNORED = 2'd0;
  localparam logic [1:0] STATUS_ACCEPT  = 2'd1;
  localparam logic [1:0] STATUS_ABORT   = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  typedef enum logic [2:0] {
    CLS_MARK,
    CLS_SOH,
    CLS_STX,
    CLS_EOT,
    CLS_ABORT,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             store_valid;
    logic [IDX_W-1:0] store_index;
    logic [7:0]       store_byte;
    logic             frame_done;
    logic             end_of_transfer;
    logic [1:0]       frame_kind;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/erx_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_fifo
// Two-entry register queue with simultaneous push and pop.
// ----------------------------------------------------------------------------
module erx_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      data_o,
  output logic                   empty_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push_ok, pop_ok;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_d  = push_ok ? ~wr_q : wr_q;
    rd_d  = pop_ok ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/erx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_front
// Removes byte stuffing and classifies each received byte.
// ----------------------------------------------------------------------------
module erx_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  rx_byte_i,
  output erx_pkg::cmd_t    cmd_o
);
  import erx_pkg::*;

  logic       esc_q, esc_d;
  logic       is_mark;
  logic [7:0] data;

  assign is_mark = (rx_byte_i == ESC_MARK) && !esc_q;
  assign data    = esc_q ? (rx_byte_i ^ ESC_XOR) : rx_byte_i;
  assign esc_d   = accept_i ? is_mark : esc_q;

  always_comb begin
    cmd_o.data = data;
    if (is_mark) begin
      cmd_o.cls = CLS_MARK;
    end else begin
      unique case (data)
        CH_SOH:       cmd_o.cls = CLS_SOH;
        CH_STX:       cmd_o.cls = CLS_STX;
        CH_EOT:       cmd_o.cls = CLS_EOT;
        CH_ABORT_LOW: cmd_o.cls = CLS_ABORT;
        default:      cmd_o.cls = CLS_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/erx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_back
// Frame tracking: header hunt, byte indexing and end of frame.
// ----------------------------------------------------------------------------
module erx_back #(
  parameter int unsigned SHORT_PAYLOAD = 128,
  parameter int unsigned LONG_PAYLOAD  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire erx_pkg::cmd_t cmd_i,
  output logic             cmd_pop_o,
  input  wire logic        res_ready_i,
  output logic             res_push_o,
  output erx_pkg::result_t res_o
);
  import erx_pkg::*;

  localparam int unsigned MAX_PAYLOAD =
    (LONG_PAYLOAD > SHORT_PAYLOAD) ? LONG_PAYLOAD : SHORT_PAYLOAD;
  localparam int unsigned RAW_W = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD);
  localparam int unsigned CNT_W = (RAW_W > IDX_W) ? RAW_W : IDX_W;
  localparam logic [CNT_W-1:0] LAST_SHORT = CNT_W'(SHORT_PAYLOAD + FRAME_OVERHEAD - 1);
  localparam logic [CNT_W-1:0] LAST_LONG  = CNT_W'(LONG_PAYLOAD + FRAME_OVERHEAD - 1);

  logic             in_frame_q, in_frame_d;
  logic             long_q, long_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] last;
  logic             step;

  assign step       = cmd_valid_i && res_ready_i;
  assign cmd_pop_o  = step;
  assign res_push_o = step;
  assign last       = long_q ? LAST_LONG : LAST_SHORT;

  always_comb begin
    in_frame_d = in_frame_q;
    long_d     = long_q;
    cnt_d      = cnt_q;
    res_o      = '0;
    if (cmd_i.cls != CLS_MARK) begin
      if (!in_frame_q) begin
        case (cmd_i.cls) inside
          CLS_SOH, CLS_STX: begin
            long_d            = (cmd_i.cls == CLS_STX);
            in_frame_d        = 1'b1;
            cnt_d             = CNT_W'(1);
            res_o.store_valid = 1'b1;
            res_o.store_byte  = cmd_i.data;
            res_o.frame_kind  = (cmd_i.cls == CLS_STX) ? KIND_LONG : KIND_SHORT;
          end
          CLS_EOT: begin
            long_d                = 1'b0;
            res_o.status          = STATUS_ACCEPT;
            res_o.frame_done      = 1'b1;
            res_o.end_of_transfer = 1'b1;
          end
          CLS_ABORT: res_o.status = STATUS_ABORT;
          default:   res_o.status = STATUS_IGNORED;
        endcase
      end else begin
        res_o.status      = STATUS_ACCEPT;
        res_o.store_valid = 1'b1;
        res_o.store_index = cnt_q[IDX_W-1:0];
        res_o.store_byte  = cmd_i.data;
        res_o.frame_kind  = long_q ? KIND_LONG : KIND_SHORT;
        if (cnt_q >= last) begin
          res_o.frame_done = 1'b1;
          in_frame_d       = 1'b0;
          cnt_d            = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      long_q     <= 1'b0;
      cnt_q      <= '0;
    end else if (step) begin
      in_frame_q <= in_frame_d;
      long_q     <= long_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/escaped_ymodem_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: a byte is held in the command queue, its result in the result queue at the ports
// throughput: one byte per cycle while the result queue is not full, set by
// the frame tracker between the two two-entry queues
// reset: asynchronous, clears escape state, frame state and both queues
// ----------------------------------------------------------------------------
// escaped_ymodem_frame_receiver
// Unstuffs received bytes and tracks ymodem frames, one result per byte.
// ----------------------------------------------------------------------------
module escaped_ymodem_frame_receiver #(
  parameter int unsigned SHORT_PAYLOAD = 128,
  parameter int unsigned LONG_PAYLOAD  = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   rx_byte_i,
  output logic              empty,
  input  wire logic         pop,
  output logic [1:0]        status_o,
  output logic              store_valid_o,
  output logic [10:0]       store_index_o,
  output logic [7:0]        store_byte_o,
  output logic              frame_done_o,
  output logic              end_of_transfer_o,
  output logic [1:0]        frame_kind_o
);
  import erx_pkg::*;

  cmd_t    cmd_in, cmd_out;
  result_t res_in, res_out;
  logic    accept;
  logic    cmd_empty, cmd_pop;
  logic    res_full, res_push;

  assign accept = push && !full;

  erx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cmd_o     (cmd_in)
  );

  erx_fifo #(.DATA_W($bits(cmd_t))) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  erx_back #(
    .SHORT_PAYLOAD (SHORT_PAYLOAD),
    .LONG_PAYLOAD  (LONG_PAYLOAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  erx_fifo #(.DATA_W($bits(result_t))) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign status_o          = res_out.status;
  assign store_valid_o     = res_out.store_valid;
  assign store_index_o     = res_out.store_index;
  assign store_byte_o      = res_out.store_byte;
  assign frame_done_o      = res_out.frame_done;
  assign end_of_transfer_o = res_out.end_of_transfer;
  assign frame_kind_o      = res_out.frame_kind;

endmodule
`default_nettype wire

// ===== hdl/erx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_checker
// Port-level checks on the escaped ymodem frame receiver.
// ----------------------------------------------------------------------------
module erx_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  status_o,
  input wire logic        store_valid_o,
  input wire logic [10:0] store_index_o,
  input wire logic [7:0]  store_byte_o,
  input wire logic        frame_done_o,
  input wire logic        end_of_transfer_o,
  input wire logic [1:0]  frame_kind_o
);
  import erx_pkg::*;

  a_kind_with_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((frame_kind_o != KIND_NONE) == store_valid_o))
    else $error("frame kind does not match store valid");

  a_eot_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && end_of_transfer_o) |->
      (frame_done_o && status_o == STATUS_ACCEPT && !store_valid_o))
    else $error("end of transfer beat malformed");

  a_idle_beat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !store_valid_o) |-> (store_index_o == 11'd0 && store_byte_o == 8'd0))
    else $error("store fields nonzero without store valid");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(store_index_o)))
    else $error("waiting result changed");

  a_full_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("input full with no result waiting");

endmodule

bind escaped_ymodem_frame_receiver erx_checker u_erx_checker (.*);
`default_nettype wire

// ===== tb/escaped_ymodem_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_ymodem_frame_receiver_tb
// Drives raw escaped serial bytes through the receiver and checks every result
// beat against an in-bench frame decoder, with random sender gaps, receiver
// stalls, a long receiver hold-off and full short and long frames.
// ----------------------------------------------------------------------------
module escaped_ymodem_frame_receiver_tb;
  import erx_pkg::*;

  localparam int unsigned SHORT_LEN   = 128;
  localparam int unsigned LONG_LEN    = 1024;
  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_LEN    = 80;

  localparam logic [7:0] CH_CAN      = 8'h18;
  localparam logic [7:0] CH_ABORT_UP = 8'h41;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_RANDOM,
    POP_PERIODIC,
    POP_BURSTY
  } pop_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  status_o;
  logic        store_valid_o;
  logic [10:0] store_index_o;
  logic [7:0]  store_byte_o;
  logic        frame_done_o;
  logic        end_of_transfer_o;
  logic [1:0]  frame_kind_o;

  escaped_ymodem_frame_receiver #(
    .SHORT_PAYLOAD (SHORT_LEN),
    .LONG_PAYLOAD  (LONG_LEN)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .rx_byte_i         (rx_byte_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .store_valid_o     (store_valid_o),
    .store_index_o     (store_index_o),
    .store_byte_o      (store_byte_o),
    .frame_done_o      (frame_done_o),
    .end_of_transfer_o (end_of_transfer_o),
    .frame_kind_o      (frame_kind_o)
  );

  always #4 clk_i = ~clk_i;

  // decoder state
  logic        esc_armed = 1'b0;
  logic        framing = 1'b0;
  logic        long_sel = 1'b0;
  int unsigned next_idx = 0;

  result_t     pending_decodes[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  bit          sender_gaps = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned rx_tick = 0;
  pop_mode_e   rx_mode = POP_ALWAYS;
  int unsigned stall_cycles = 0;

  function automatic result_t decode_rx_byte(input logic [7:0] raw);
    result_t     r;
    logic [7:0]  b;
    int unsigned last;
    r = '0;
    r.status = STATUS_IGNORED;
    r.frame_kind = KIND_NONE;
    b = raw;
    if (raw == ESC_MARK && !esc_armed) begin
      esc_armed = 1'b1;
    end else begin
      if (esc_armed) begin
        b = raw ^ ESC_XOR;
        esc_armed = 1'b0;
      end
      if (!framing) begin
        if (b == CH_SOH || b == CH_STX) begin
          long_sel = (b == CH_STX);
          framing = 1'b1;
          next_idx = 1;
          r.store_valid = 1'b1;
          r.store_index = '0;
          r.store_byte = b;
          r.frame_kind = long_sel ? KIND_LONG : KIND_SHORT;
        end else if (b == CH_EOT) begin
          long_sel = 1'b0;
          r.status = STATUS_ACCEPT;
          r.frame_done = 1'b1;
          r.end_of_transfer = 1'b1;
        end else if (b == CH_ABORT_LOW) begin
          r.status = STATUS_ABORT;
        end
      end else begin
        last = (long_sel ? LONG_LEN : SHORT_LEN) + FRAME_OVERHEAD - 1;
        r.status = STATUS_ACCEPT;
        r.store_valid = 1'b1;
        r.store_index = next_idx[IDX_W-1:0];
        r.store_byte = b;
        r.frame_kind = long_sel ? KIND_LONG : KIND_SHORT;
        if (next_idx >= last) begin
          r.frame_done = 1'b1;
          framing = 1'b0;
          next_idx = 0;
        end else begin
          next_idx++;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result check first, then record the byte accepted at this edge
  always @(posedge clk_i) begin : beat_monitor
    result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_decodes.size() == 0) begin
          $error("result beat with no byte outstanding");
          mismatches++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("status", want.status, status_o);
          check_field("store_valid", want.store_valid, store_valid_o);
          check_field("store_index", want.store_index, store_index_o);
          check_field("store_byte", want.store_byte, store_byte_o);
          check_field("frame_done", want.frame_done, frame_done_o);
          check_field("end_of_transfer", want.end_of_transfer, end_of_transfer_o);
          check_field("frame_kind", want.frame_kind, frame_kind_o);
        end
      end
      if (push && !full) begin
        pending_decodes.push_back(decode_rx_byte(rx_byte_i));
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles--;
    end else begin
      case (rx_mode)
        POP_ALWAYS:   pop <= 1'b1;
        POP_RANDOM:   pop <= ($urandom_range(0, 99) < 60);
        POP_PERIODIC: pop <= ((rx_tick % 5) != 0);
        default:      pop <= (rx_tick[4:3] != 2'b00);
      endcase
    end
    rx_tick++;
    if (rx_tick % 256 == 0) begin
      rx_mode = pop_mode_e'($urandom_range(0, 3));
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
        rx_byte_i <= 8'($urandom);
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk_i);
    push <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    beats_sent++;
  endtask

  task automatic send_stuffed(input logic [7:0] b, input int unsigned esc_pct);
    if (b == ESC_MARK || $urandom_range(0, 99) < esc_pct) begin
      send_byte(ESC_MARK);
      send_byte(b ^ ESC_XOR);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_frame(input bit long_f, input bit hdr_esc, input bit tail_esc);
    int unsigned body;
    body = (long_f ? LONG_LEN : SHORT_LEN) + FRAME_OVERHEAD - 1;
    send_stuffed(long_f ? CH_STX : CH_SOH, hdr_esc ? 100 : 10);
    for (int unsigned k = 1; k <= body; k++) begin
      send_stuffed(8'($urandom), (k == body && tail_esc) ? 100 : 12);
    end
  endtask

  task automatic send_noise();
    logic [7:0] v;
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 5))
        0:       v = CH_EOT;
        1:       v = CH_ABORT_LOW;
        2:       v = CH_ABORT_UP;
        3:       v = CH_CAN;
        default: v = 8'($urandom);
      endcase
      if (v == CH_SOH || v == CH_STX) begin
        v = 8'h00;
      end
      send_stuffed(v, 25);
    end
    // dangling escape that corrupts the next header
    if ($urandom_range(0, 7) == 0) begin
      send_byte(ESC_MARK);
    end
  endtask

  task automatic test_hunting_bytes();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'hff, CH_CAN, CH_ABORT_UP, CH_ABORT_LOW, CH_EOT,
            ESC_MARK, CH_EOT ^ ESC_XOR, ESC_MARK, CH_ABORT_LOW ^ ESC_XOR,
            ESC_MARK, ESC_MARK, ESC_MARK, 8'h5d, ESC_MARK, 8'hff,
            8'h7f, 8'h80, CH_EOT, CH_ABORT_LOW, 8'h55, 8'haa};
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
    wait_drained();
  endtask

  task automatic test_receiver_holdoff();
    sender_gaps = 1'b0;
    hold_cycles = HOLD_LEN;
    send_frame(1'b0, 1'b0, 1'b0);
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    bit          long_done;
    int unsigned shorts;
    int unsigned shorts_before_long;
    long_done = 1'b0;
    shorts = 0;
    shorts_before_long = $urandom_range(1, 3);
    send_frame(1'b0, 1'b1, 1'b1);
    while (!long_done || beats_sent < ITEM_TARGET) begin
      if (!long_done && shorts >= shorts_before_long) begin
        send_frame(1'b1, 1'($urandom), 1'($urandom));
        long_done = 1'b1;
      end else if ($urandom_range(0, 9) < 3) begin
        send_noise();
      end else begin
        send_frame(1'b0, 1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 3) == 0));
        shorts++;
      end
      if ($urandom_range(0, 5) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_hunting_bytes();
    test_receiver_holdoff();
    test_random_traffic();
    repeat (10) @(posedge clk_i);
    if (pending_decodes.size() != 0) begin
      $error("%0d result beats never arrived", pending_decodes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/erx_pkg.sv
hdl/erx_fifo.sv
hdl/erx_front.sv
hdl/erx_back.sv
hdl/escaped_ymodem_frame_receiver.sv
hdl/erx_checker.sv
tb/escaped_ymodem_frame_receiver_tb.sv
